// ===== rtl/lqe_pkg.sv =====
package lqe_pkg;

    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int NUM_W   = 61;
    localparam int ROOT_W  = 31;
    localparam int QUO_W   = 30;
    localparam int DIV_W   = 32;

    localparam logic [CIDX_W-1:0] CFG_SCALE_X = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SCALE_Y = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BIAS_X  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BIAS_Y  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_DEPTH   = 3'd4;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               nx;
        logic               ny;
        logic               zero;
    } seg_t;

endpackage

// ===== rtl/lqe_isqrt.sv =====
module lqe_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [lqe_pkg::NUM_W-1:0]  radicand,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [lqe_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int STEPS = lqe_pkg::ROOT_W;
    localparam int RW    = 2 * STEPS;

    logic [RW-1:0]     n_reg     [STEPS];
    logic [RW-1:0]     res_reg   [STEPS];
    logic [SIDE_W-1:0] side_reg  [STEPS];
    logic [STEPS-1:0]  valid_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [RW-1:0]     n_cur;
        logic [RW-1:0]     res_cur;
        logic [RW-1:0]     bit_k;
        logic [RW-1:0]     trial;
        logic              v_cur;
        logic [SIDE_W-1:0] side_cur;

        if (k == 0) begin : g_first
            assign n_cur    = RW'(radicand);
            assign res_cur  = '0;
            assign v_cur    = in_valid;
            assign side_cur = in_side;
        end
        else begin : g_next
            assign n_cur    = n_reg[k-1];
            assign res_cur  = res_reg[k-1];
            assign v_cur    = valid_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign bit_k = RW'(1) << (2 * (STEPS - 1 - k));
        assign trial = res_cur + bit_k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_cur;
            if (n_cur >= trial)
            begin
                n_reg[k]   <= n_cur - trial;
                res_reg[k] <= (res_cur >> 1) + bit_k;
            end
            else
            begin
                n_reg[k]   <= n_cur;
                res_reg[k] <= res_cur >> 1;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][lqe_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ===== rtl/lqe_div.sv =====
module lqe_div #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [lqe_pkg::NUM_W-1:0] num_x,
    input  logic [lqe_pkg::NUM_W-1:0] num_y,
    input  logic [lqe_pkg::DIV_W-1:0] divisor,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [lqe_pkg::QUO_W-1:0] quo_x,
    output logic [lqe_pkg::QUO_W-1:0] quo_y,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int STEPS = lqe_pkg::QUO_W;
    localparam int NW    = lqe_pkg::NUM_W;
    localparam int CW    = NW + 1;

    logic [NW-1:0]               rx_reg   [STEPS];
    logic [NW-1:0]               ry_reg   [STEPS];
    logic [STEPS-1:0]            qx_reg   [STEPS];
    logic [STEPS-1:0]            qy_reg   [STEPS];
    logic [lqe_pkg::DIV_W-1:0]   d_reg    [STEPS];
    logic [SIDE_W-1:0]           side_reg [STEPS];
    logic [STEPS-1:0]            valid_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [NW-1:0]             rx_cur;
        logic [NW-1:0]             ry_cur;
        logic [STEPS-1:0]          qx_cur;
        logic [STEPS-1:0]          qy_cur;
        logic [lqe_pkg::DIV_W-1:0] d_cur;
        logic                      v_cur;
        logic [SIDE_W-1:0]         side_cur;
        logic [CW-1:0]             dsh;
        logic                      ge_x;
        logic                      ge_y;

        if (k == 0) begin : g_first
            assign rx_cur   = num_x;
            assign ry_cur   = num_y;
            assign qx_cur   = '0;
            assign qy_cur   = '0;
            assign d_cur    = divisor;
            assign v_cur    = in_valid;
            assign side_cur = in_side;
        end
        else begin : g_next
            assign rx_cur   = rx_reg[k-1];
            assign ry_cur   = ry_reg[k-1];
            assign qx_cur   = qx_reg[k-1];
            assign qy_cur   = qy_reg[k-1];
            assign d_cur    = d_reg[k-1];
            assign v_cur    = valid_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign dsh  = CW'(d_cur) << (STEPS - 1 - k);
        assign ge_x = CW'(rx_cur) >= dsh;
        assign ge_y = CW'(ry_cur) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[k]    <= d_cur;
            side_reg[k] <= side_cur;
            rx_reg[k]   <= ge_x ? NW'(CW'(rx_cur) - dsh) : rx_cur;
            ry_reg[k]   <= ge_y ? NW'(CW'(ry_cur) - dsh) : ry_cur;
            qx_reg[k]   <= qx_cur | (STEPS'(ge_x) << (STEPS - 1 - k));
            qy_reg[k]   <= qy_cur | (STEPS'(ge_y) << (STEPS - 1 - k));
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign quo_x     = qx_reg[STEPS-1];
    assign quo_y     = qy_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ===== rtl/line_to_quad_expander_core.sv =====
// Path: an accepted start runs through v1_reg to v5_reg, the square root, the
// divider, off_valid_reg, run_reg, c1_valid_reg and c2_valid_reg to strobe;
// the four corners follow on consecutive cycles. Segments overlap; busy
// blocks start after each accepted one until gap_reg has counted down.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the registers
// with unit scale, zero bias and zero depth. The receiver cannot stall.
module line_to_quad_expander_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          start_x,
    input  logic signed [31:0]          start_y,
    input  logic signed [31:0]          end_x,
    input  logic signed [31:0]          end_y,
    input  logic [30:0]                 line_width,
    input  logic                        cfg_we,
    input  logic [lqe_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [lqe_pkg::CFG_W-1:0]   cfg_data,
    output logic                        strobe,
    output logic [1:0]                  corner,
    output logic signed [31:0]          pos_x,
    output logic signed [31:0]          pos_y,
    output logic signed [31:0]          depth,
    output logic                        tex_u,
    output logic                        tex_v,
    output logic                        last
);

    localparam int SEG_W  = $bits(lqe_pkg::seg_t);
    localparam int NW     = lqe_pkg::NUM_W;
    localparam int SQ_SW  = SEG_W + 2 * NW;
    localparam logic signed [65:0] POS_MAX = 66'sd2147483647;
    localparam logic signed [65:0] NEG_MIN = -66'sd2147483648;

    // configuration
    logic signed [31:0] scale_x_reg, scale_y_reg, bias_x_reg, bias_y_reg, depth_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg     <= 32'sd1 <<< FRAC_BITS;
            scale_y_reg     <= 32'sd1 <<< FRAC_BITS;
            bias_x_reg      <= '0;
            bias_y_reg      <= '0;
            depth_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lqe_pkg::CFG_SCALE_X: scale_x_reg     <= cfg_data;
                lqe_pkg::CFG_SCALE_Y: scale_y_reg     <= cfg_data;
                lqe_pkg::CFG_BIAS_X:  bias_x_reg      <= cfg_data;
                lqe_pkg::CFG_BIAS_Y:  bias_y_reg      <= cfg_data;
                lqe_pkg::CFG_DEPTH:   depth_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // issue spacing
    logic       go;
    logic [1:0] gap_reg;

    assign go   = start && !busy;
    assign busy = gap_reg != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= '0;
        end
        else if (go)
        begin
            gap_reg <= 2'd3;
        end
        else if (gap_reg != 2'd0)
        begin
            gap_reg <= gap_reg - 2'd1;
        end
    end

    // front stages
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    lqe_pkg::seg_t      s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic signed [32:0] px_reg, py_reg;
    logic [30:0]        w1_reg, w2_reg, w3_reg;
    logic [32:0]        mx_reg, my_reg;
    logic [5:0]         lead_reg;
    logic [29:0]        mxs_reg, mys_reg;
    logic [59:0]        sqx_reg, sqy_reg;
    logic [NW-1:0]      numx4_reg, numy4_reg, numx5_reg, numy5_reg;
    logic [NW-1:0]      sum_reg;

    logic [32:0]        mx_c, my_c, m_c;
    logic [5:0]         lead_c;
    logic [29:0]        mxs_c, mys_c;

    always_comb
    begin
        mx_c = px_reg[32] ? 33'(-px_reg) : 33'(px_reg);
        my_c = py_reg[32] ? 33'(-py_reg) : 33'(py_reg);
        m_c  = (mx_c > my_c) ? mx_c : my_c;
        lead_c = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (m_c[i])
            begin
                lead_c = 6'(i);
            end
        end
    end

    always_comb
    begin
        if (lead_reg > 6'd29)
        begin
            mxs_c = 30'(mx_reg >> (lead_reg - 6'd29));
            mys_c = 30'(my_reg >> (lead_reg - 6'd29));
        end
        else
        begin
            mxs_c = 30'(mx_reg << (6'd29 - lead_reg));
            mys_c = 30'(my_reg << (6'd29 - lead_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg.ax   <= start_x;
        s1_reg.ay   <= start_y;
        s1_reg.bx   <= end_x;
        s1_reg.by   <= end_y;
        s1_reg.nx   <= 1'b0;
        s1_reg.ny   <= 1'b0;
        s1_reg.zero <= 1'b0;
        px_reg      <= 33'(start_y) - 33'(end_y);
        py_reg      <= 33'(end_x) - 33'(start_x);
        w1_reg      <= line_width;

        s2_reg      <= '{ax: s1_reg.ax, ay: s1_reg.ay, bx: s1_reg.bx, by: s1_reg.by,
                         nx: px_reg[32], ny: py_reg[32], zero: m_c == 33'd0};
        mx_reg      <= mx_c;
        my_reg      <= my_c;
        lead_reg    <= lead_c;
        w2_reg      <= w1_reg;

        s3_reg      <= s2_reg;
        mxs_reg     <= s2_reg.zero ? 30'd0 : mxs_c;
        mys_reg     <= s2_reg.zero ? 30'd0 : mys_c;
        w3_reg      <= w2_reg;

        s4_reg      <= s3_reg;
        sqx_reg     <= 60'(mxs_reg) * 60'(mxs_reg);
        sqy_reg     <= 60'(mys_reg) * 60'(mys_reg);
        numx4_reg   <= NW'(mxs_reg) * NW'(w3_reg);
        numy4_reg   <= NW'(mys_reg) * NW'(w3_reg);

        s5_reg      <= s4_reg;
        sum_reg     <= NW'(sqx_reg) + NW'(sqy_reg);
        numx5_reg   <= numx4_reg;
        numy5_reg   <= numy4_reg;
    end

    // length and quotient
    logic                         sq_valid;
    logic [lqe_pkg::ROOT_W-1:0]   root;
    logic [SQ_SW-1:0]             sq_side;
    lqe_pkg::seg_t                sq_seg;
    logic [NW-1:0]                sq_numx, sq_numy;

    lqe_isqrt #(
        .SIDE_W (SQ_SW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .radicand  (sum_reg),
        .in_side   ({s5_reg, numx5_reg, numy5_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .out_side  (sq_side)
    );

    assign {sq_seg, sq_numx, sq_numy} = sq_side;

    logic                       dv_valid;
    logic [lqe_pkg::QUO_W-1:0]  qx, qy;
    lqe_pkg::seg_t              dv_seg;

    lqe_div #(
        .SIDE_W (SEG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .num_x     (sq_numx),
        .num_y     (sq_numy),
        .divisor   ({root, 1'b0}),
        .in_side   (sq_seg),
        .out_valid (dv_valid),
        .quo_x     (qx),
        .quo_y     (qy),
        .out_side  (dv_seg)
    );

    // signed offset
    logic               off_valid_reg;
    lqe_pkg::seg_t      off_seg_reg;
    logic signed [30:0] ox_reg, oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg <= 1'b0;
        end
        else
        begin
            off_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        off_seg_reg <= dv_seg;
        if (dv_seg.zero)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else
        begin
            ox_reg <= dv_seg.nx ? -31'(qx) : 31'(qx);
            oy_reg <= dv_seg.ny ? -31'(qy) : 31'(qy);
        end
    end

    // corner sequencer
    logic               run_reg;
    logic [1:0]         cnt_reg;
    lqe_pkg::seg_t      item_reg;
    logic signed [30:0] iox_reg, ioy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (off_valid_reg)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            run_reg <= cnt_reg != 2'd3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (off_valid_reg)
        begin
            item_reg <= off_seg_reg;
            iox_reg  <= ox_reg;
            ioy_reg  <= oy_reg;
        end
    end

    // corner arithmetic
    logic               c1_valid_reg, c2_valid_reg;
    logic [1:0]         c1_corner_reg, c2_corner_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [64:0] prx_reg, pry_reg;
    logic signed [32:0] base_x, base_y;
    logic signed [64:0] shx, shy;
    logic signed [65:0] rx, ry;

    assign base_x = cnt_reg[1] ? 33'(item_reg.bx) : 33'(item_reg.ax);
    assign base_y = cnt_reg[1] ? 33'(item_reg.by) : 33'(item_reg.ay);
    assign shx    = prx_reg >>> FRAC_BITS;
    assign shy    = pry_reg >>> FRAC_BITS;
    assign rx     = 66'(shx) + 66'(bias_x_reg);
    assign ry     = 66'(shy) + 66'(bias_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            strobe       <= 1'b0;
        end
        else
        begin
            c1_valid_reg <= run_reg;
            c2_valid_reg <= c1_valid_reg;
            strobe       <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_corner_reg <= cnt_reg;
        cx_reg <= cnt_reg[0] ? base_x + 33'(iox_reg) : base_x - 33'(iox_reg);
        cy_reg <= cnt_reg[0] ? base_y + 33'(ioy_reg) : base_y - 33'(ioy_reg);

        c2_corner_reg <= c1_corner_reg;
        prx_reg       <= 65'(cx_reg) * 65'(scale_x_reg);
        pry_reg       <= 65'(cy_reg) * 65'(scale_y_reg);

        corner <= c2_corner_reg;
        tex_u  <= c2_corner_reg[1];
        tex_v  <= c2_corner_reg[0];
        last   <= c2_corner_reg == 2'd3;
        depth  <= depth_value_reg;
        if (rx > POS_MAX)
            pos_x <= 32'sh7FFFFFFF;
        else if (rx < NEG_MIN)
            pos_x <= 32'sh80000000;
        else
            pos_x <= 32'(rx);
        if (ry > POS_MAX)
            pos_y <= 32'sh7FFFFFFF;
        else if (ry < NEG_MIN)
            pos_y <= 32'sh80000000;
        else
            pos_y <= 32'(ry);
    end

    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy ##1 busy ##1 busy)
        else $error("transaction accepted inside the spacing window");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && corner != 2'd0 |-> $past(strobe) && $past(corner) == corner - 2'd1)
        else $error("corner sequence broken");

    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (corner == 2'd3)) && tex_u == corner[1] && tex_v == corner[0])
        else $error("corner tags inconsistent");

    a_seq_done: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && corner == 2'd3 |=> !strobe || corner == 2'd0)
        else $error("corners after the last of a segment");

endmodule

// ===== tb/sv/line_to_quad_expander_core_test.sv =====
module line_to_quad_expander_core_test;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 90;
    localparam int IDX_W = lqe_pkg::CIDX_W;

    typedef struct {
        logic [1:0]         corner;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               u;
        logic               v;
        logic               lst;
    } vertex_t;

    typedef struct {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        w;
        logic               known;
        logic signed [31:0] ex [4];
        logic signed [31:0] ey [4];
    } segment_t;

    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [30:0] line_width = '0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [lqe_pkg::CFG_W-1:0] cfg_data = '0;
    logic strobe;
    logic [1:0] corner;
    logic signed [31:0] pos_x, pos_y, depth;
    logic tex_u, tex_v, last;

    logic signed [31:0] scale_x_m, scale_y_m, bias_x_m, bias_y_m, depth_m;
    vertex_t vertex_q [$];
    int mismatches = 0;
    int idle_cycles = 0;
    logic accepted_now;

    line_to_quad_expander_core #(.FRAC_BITS(FRAC)) uut (.*);

    always #5 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] place(longint c, logic signed [31:0] sc,
                                                 logic signed [31:0] bi);
        longint r;
        r = ((c * longint'(sc)) >>> FRAC) + longint'(bi);
        if (r > longint'(MAXV))
            r = longint'(MAXV);
        if (r < longint'(MINV))
            r = longint'(MINV);
        return r[31:0];
    endfunction

    task automatic expand_segment(segment_t s);
        longint ax, ay, bx, by, w, px, py, mx, my, m, len, ox, oy, sx, sy, cx, cy;
        vertex_t vx;
        ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
        w = longint'({1'b0, s.w});
        px = ay - by;
        py = bx - ax;
        mx = px < 0 ? -px : px;
        my = py < 0 ? -py : py;
        m = mx > my ? mx : my;
        ox = 0;
        oy = 0;
        if (m != 0)
        begin
            while (m >= (64'sd1 << 30))
            begin
                mx >>= 1; my >>= 1; m >>= 1;
            end
            while (m < (64'sd1 << 29))
            begin
                mx <<= 1; my <<= 1; m <<= 1;
            end
            len = root_floor(mx * mx + my * my);
            sx = px < 0 ? -mx : mx;
            sy = py < 0 ? -my : my;
            ox = (sx * w) / (2 * len);
            oy = (sy * w) / (2 * len);
        end
        for (int k = 0; k < 4; k++)
        begin
            cx = k[1] ? bx : ax;
            cy = k[1] ? by : ay;
            cx = k[0] ? cx + ox : cx - ox;
            cy = k[0] ? cy + oy : cy - oy;
            vx.corner = k[1:0];
            vx.x = s.known ? s.ex[k] : place(cx, scale_x_m, bias_x_m);
            vx.y = s.known ? s.ey[k] : place(cy, scale_y_m, bias_y_m);
            vx.z = depth_m;
            vx.u = k[1];
            vx.v = k[0];
            vx.lst = (k == 3);
            vertex_q.push_back(vx);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lqe_pkg::CFG_SCALE_X: scale_x_m = val;
            lqe_pkg::CFG_SCALE_Y: scale_y_m = val;
            lqe_pkg::CFG_BIAS_X:  bias_x_m = val;
            lqe_pkg::CFG_BIAS_Y:  bias_y_m = val;
            lqe_pkg::CFG_DEPTH:   depth_m = val;
            default: ;
        endcase
    endtask

    task automatic send(segment_t s);
        int gap;
        start <= 1'b1;
        start_x <= s.ax;
        start_y <= s.ay;
        end_x <= s.bx;
        end_y <= s.by;
        line_width <= s.w;
        do
            @(posedge clk);
        while (busy);
        expand_segment(s);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_coord(int style, logic signed [31:0] near);
        case (style)
            0: return $urandom;
            1: return near + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2: return near + $signed($urandom_range(0, 8)) - 4;
            default: return $urandom_range(0, 1) ? MAXV : MINV;
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        int style;
        style = $urandom_range(0, 9);
        s.known = 1'b0;
        s.ax = $urandom;
        s.ay = $urandom;
        if (style < 2)
        begin
            s.ax = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            s.ay = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        s.bx = pick_coord(style < 4 ? 0 : (style < 7 ? 1 : (style < 9 ? 2 : 3)), s.ax);
        s.by = pick_coord(style < 4 ? 0 : (style < 7 ? 1 : (style < 9 ? 2 : 3)), s.ay);
        if ($urandom_range(0, 11) == 0)
        begin
            s.bx = s.ax;
            s.by = s.ay;
        end
        case ($urandom_range(0, 7))
            0: s.w = '0;
            1: s.w = '1;
            2, 3: s.w = 31'($urandom_range(0, 1 << 22));
            default: s.w = 31'($urandom);
        endcase
        return s;
    endfunction

    function automatic segment_t seg(logic signed [31:0] ax, ay, bx, by, logic [30:0] w);
        segment_t s;
        s.ax = ax; s.ay = ay; s.bx = bx; s.by = by; s.w = w;
        s.known = 1'b0;
        return s;
    endfunction

    function automatic segment_t seg_known(logic signed [31:0] ax, ay, bx, by,
                                           logic [30:0] w, logic signed [31:0] x0, x1,
                                           x2, x3, y0, y1, y2, y3);
        segment_t s;
        s = seg(ax, ay, bx, by, w);
        s.known = 1'b1;
        s.ex = '{x0, x1, x2, x3};
        s.ey = '{y0, y1, y2, y3};
        return s;
    endfunction

    always @(posedge clk)
    begin
        accepted_now = start && !busy && rst_n;
        if (rst_n && strobe)
        begin
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex: corner %0d x %h y %h", corner, pos_x, pos_y);
            end
            else
            begin
                vertex_t e;
                e = vertex_q.pop_front();
                if (corner !== e.corner || pos_x !== e.x || pos_y !== e.y || depth !== e.z
                    || tex_u !== e.u || tex_v !== e.v || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: exp c%0d x %h y %h z %h u%b v%b l%b,",
                                 e.corner, e.x, e.y, e.z, e.u, e.v, e.lst,
                                 " got c%0d x %h y %h z %h u%b v%b l%b",
                                 corner, pos_x, pos_y, depth, tex_u, tex_v, last);
                end
            end
        end
        if (accepted_now || (rst_n && strobe))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    segment_t directed [$];

    initial
    begin
        logic signed [31:0] cfg_vals [5];
        scale_x_m = ONE; scale_y_m = ONE;
        bias_x_m = '0; bias_y_m = '0; depth_m = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(seg_known(ONE, 2 * ONE, ONE, 2 * ONE, 31'h20000,
            ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        directed.push_back(seg_known(0, 0, ONE, 0, 31'h20000,
            0, 0, ONE, ONE, -ONE, ONE, -ONE, ONE));
        directed.push_back(seg_known(MAXV, MAXV, MAXV, MAXV, '1,
            MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        directed.push_back(seg_known(MINV, MINV, MINV, MINV, '1,
            MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        directed.push_back(seg(MINV, MINV, MAXV, MAXV, '1));
        directed.push_back(seg(MAXV, MINV, MINV, MAXV, '0));
        directed.push_back(seg(MAXV, MAXV, MINV, MINV, '1));
        directed.push_back(seg(0, 0, 0, ONE, 31'h40000));
        directed.push_back(seg(0, 0, 3 * ONE, 4 * ONE, 31'ha0000));
        directed.push_back(seg(0, 0, 1, 0, '1));
        directed.push_back(seg(0, 0, 0, -1, '1));
        directed.push_back(seg(5, 7, 6, 8, 31'd1));
        directed.push_back(seg(-ONE, ONE, ONE, -ONE, 31'h7fff0000));
        directed.push_back(seg(MAXV, 0, MAXV - 1, 0, '1));
        directed.push_back(seg(32'sh40000000, -32'sh40000000, -32'sh40000000,
                               32'sh40000000, 31'h12345678));
        directed.push_back(seg(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                               31'h2aaaaaaa));
        directed.push_back(seg(0, 0, 32'h7fff0000, 1, 31'h55555555));
        foreach (directed[i])
            send(directed[i]);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: cfg_vals = '{MAXV, MINV, MAXV, MINV, MAXV};
                1: cfg_vals = '{MINV, MAXV, MINV, MAXV, MINV};
                2: cfg_vals = '{0, 0, 32'sh12345678, -32'sh00abcdef, 32'sh7ffe0001};
                3: cfg_vals = '{ONE, -ONE, 0, 0, 0};
                default: cfg_vals = '{$urandom, $urandom, $urandom, $urandom, $urandom};
            endcase
            write_reg(lqe_pkg::CFG_SCALE_X, cfg_vals[0]);
            write_reg(lqe_pkg::CFG_SCALE_Y, cfg_vals[1]);
            write_reg(lqe_pkg::CFG_BIAS_X, cfg_vals[2]);
            write_reg(lqe_pkg::CFG_BIAS_Y, cfg_vals[3]);
            write_reg(lqe_pkg::CFG_DEPTH, cfg_vals[4]);
            write_reg(IDX_W'($urandom_range(5, 7)), $urandom);
            for (int n = 0; n < 27; n++)
                send(random_segment());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== line_to_quad_expander_core.f =====
rtl/lqe_pkg.sv
rtl/lqe_isqrt.sv
rtl/lqe_div.sv
rtl/line_to_quad_expander_core.sv
tb/sv/line_to_quad_expander_core_test.sv
